>>> rtl/core/rtmh_pkg.sv
`default_nettype none

package rtmh_pkg;

  // operation codes carried in the item
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_BEST   = 2'd2,
    FN_EXACT  = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_KEPT      = 3'd2,
    ST_FULL      = 3'd3,
    ST_DELETED   = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_FOUND     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    FSM_CLEAR  = 3'd0,
    FSM_IDLE   = 3'd1,
    FSM_SCAN   = 3'd2,
    FSM_DECIDE = 3'd3
  } fsm_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] dest_node;
    logic [7:0] via_node;
    logic [7:0] hop_count;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] found_via;
    logic [7:0] found_hops;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/route_table_min_hop_unit.sv
// route table, min-hop lookup: one item at a time, each item scans every slot
// a new item is accepted only once the last one has been scanned and its result has
//   been registered; the scan reads the slots through the single read port of the table ram
// reset: synchronous, active low; afterwards a clearing pass writes every slot
//   invalid, with in_ready low until it completes
`default_nettype none

module route_table_min_hop_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int NODE_BITS   = 8,
  parameter int HOP_BITS    = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rtmh_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rtmh_pkg::out_item_t     out_data
);

  localparam int IDX_BITS = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W  = 1 + 2 * NODE_BITS + HOP_BITS;
  // entry layout: valid | dest | via | hops
  localparam int VIA_LSB  = HOP_BITS;
  localparam int DEST_LSB = HOP_BITS + NODE_BITS;
  localparam int VLD_BIT  = ENTRY_W - 1;

  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(TABLE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_END  = CNT_BITS'(TABLE_DEPTH);

  rtmh_pkg::fsm_t state_r, state_nxt;

  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  // item being served, cut to the configured widths
  rtmh_pkg::func_t     func_r;
  logic [NODE_BITS-1:0] dest_r;
  logic [NODE_BITS-1:0] via_r;
  logic [HOP_BITS-1:0]  hops_r;

  // scan results
  logic                 ex_hit_r;
  logic [IDX_BITS-1:0]  ex_idx_r;
  logic [NODE_BITS-1:0] ex_via_r;
  logic [HOP_BITS-1:0]  ex_hops_r;
  logic                 best_hit_r;
  logic [NODE_BITS-1:0] best_via_r;
  logic [HOP_BITS-1:0]  best_hops_r;
  logic                 free_hit_r;
  logic [IDX_BITS-1:0]  free_idx_r;

  // table ram
  logic                ram_we;
  logic [IDX_BITS-1:0] ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;

  // slot read back during the scan
  logic                 rd_valid;
  logic [NODE_BITS-1:0] rd_dest;
  logic [NODE_BITS-1:0] rd_via;
  logic [HOP_BITS-1:0]  rd_hops;
  logic [IDX_BITS-1:0]  rd_idx;
  logic                 rd_live;
  logic                 rd_dest_eq;
  logic                 rd_exact;

  logic                in_fire;
  logic                decide_go;
  rtmh_pkg::out_item_t res;

  logic                out_valid_r;
  rtmh_pkg::out_item_t out_data_r;

  rtmh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_r[IDX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_valid   = ram_rdata[VLD_BIT];
  assign rd_dest    = ram_rdata[DEST_LSB +: NODE_BITS];
  assign rd_via     = ram_rdata[VIA_LSB +: NODE_BITS];
  assign rd_hops    = ram_rdata[HOP_BITS-1:0];
  // the ram read is registered, so read data belongs to the slot one below cnt_r
  assign rd_idx     = IDX_BITS'(cnt_r - 1'b1);
  assign rd_live    = (state_r == rtmh_pkg::FSM_SCAN) && (cnt_r != '0);
  assign rd_dest_eq = rd_valid && (rd_dest == dest_r);
  assign rd_exact   = rd_dest_eq && (rd_via == via_r);

  assign in_fire   = in_valid && in_ready;
  // the result register must be free before the table is touched
  assign decide_go = (state_r == rtmh_pkg::FSM_DECIDE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtmh_pkg::FSM_CLEAR: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = rtmh_pkg::FSM_IDLE;
        end
      end
      rtmh_pkg::FSM_IDLE: begin
        if (in_valid) begin
          state_nxt = rtmh_pkg::FSM_SCAN;
        end
      end
      rtmh_pkg::FSM_SCAN: begin
        if (cnt_r == CNT_END) begin
          state_nxt = rtmh_pkg::FSM_DECIDE;
        end
      end
      rtmh_pkg::FSM_DECIDE: begin
        if (decide_go) begin
          state_nxt = rtmh_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = rtmh_pkg::FSM_CLEAR;
    endcase
  end

  // outputs of the state machine: ram control and the result
  always_comb begin
    in_ready       = 1'b0;
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[IDX_BITS-1:0];
    ram_wdata      = '0;
    res.status     = rtmh_pkg::ST_NOT_FOUND;
    res.found_via  = '0;
    res.found_hops = '0;
    unique case (state_r)
      rtmh_pkg::FSM_CLEAR: begin
        ram_we = 1'b1;
      end
      rtmh_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
      end
      rtmh_pkg::FSM_SCAN: begin
        ram_re = (cnt_r != CNT_END);
      end
      rtmh_pkg::FSM_DECIDE: begin
        unique case (func_r)
          rtmh_pkg::FN_INSERT: begin
            ram_wdata = {1'b1, dest_r, via_r, hops_r};
            if (ex_hit_r) begin
              ram_waddr = ex_idx_r;
              if (ex_hops_r <= hops_r) begin
                res.status = rtmh_pkg::ST_KEPT;
              end else begin
                res.status = rtmh_pkg::ST_REPLACED;
                ram_we     = decide_go;
              end
            end else if (free_hit_r) begin
              ram_waddr  = free_idx_r;
              res.status = rtmh_pkg::ST_INSERTED;
              ram_we     = decide_go;
            end else begin
              res.status = rtmh_pkg::ST_FULL;
            end
          end
          rtmh_pkg::FN_DELETE: begin
            ram_waddr = ex_idx_r;
            if (ex_hit_r) begin
              res.status = rtmh_pkg::ST_DELETED;
              ram_we     = decide_go;
            end
          end
          rtmh_pkg::FN_BEST: begin
            if (best_hit_r) begin
              res.status     = rtmh_pkg::ST_FOUND;
              res.found_via  = 8'(best_via_r);
              res.found_hops = 8'(best_hops_r);
            end
          end
          rtmh_pkg::FN_EXACT: begin
            if (ex_hit_r) begin
              res.status     = rtmh_pkg::ST_FOUND;
              res.found_via  = 8'(ex_via_r);
              res.found_hops = 8'(ex_hops_r);
            end
          end
          default: res.status = rtmh_pkg::ST_NOT_FOUND;
        endcase
      end
      default: in_ready = 1'b0;
    endcase
  end

  // slot counter: clearing pass, then scan address
  always_comb begin
    cnt_nxt = cnt_r;
    unique case (state_r)
      rtmh_pkg::FSM_CLEAR: begin
        cnt_nxt = (cnt_r == CNT_LAST) ? '0 : cnt_r + 1'b1;
      end
      rtmh_pkg::FSM_IDLE:   cnt_nxt = '0;
      rtmh_pkg::FSM_SCAN:   cnt_nxt = cnt_r + 1'b1;
      rtmh_pkg::FSM_DECIDE: cnt_nxt = '0;
      default:              cnt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtmh_pkg::FSM_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (decide_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r     <= in_data.func;
      dest_r     <= NODE_BITS'(in_data.dest_node);
      via_r      <= NODE_BITS'(in_data.via_node);
      hops_r     <= HOP_BITS'(in_data.hop_count);
      ex_hit_r   <= 1'b0;
      best_hit_r <= 1'b0;
      free_hit_r <= 1'b0;
    end else if (rd_live) begin
      // first exact match wins
      if (rd_exact && !ex_hit_r) begin
        ex_hit_r  <= 1'b1;
        ex_idx_r  <= rd_idx;
        ex_via_r  <= rd_via;
        ex_hops_r <= rd_hops;
      end
      // strictly fewer hops only, so ties stay with the lower slot
      if (rd_dest_eq && (!best_hit_r || (rd_hops < best_hops_r))) begin
        best_hit_r  <= 1'b1;
        best_via_r  <= rd_via;
        best_hops_r <= rd_hops;
      end
      if (!rd_valid && !free_hit_r) begin
        free_hit_r <= 1'b1;
        free_idx_r <= rd_idx;
      end
    end
    if (decide_go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/core/rtmh_ram.sv
`default_nettype none

module rtmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
